### rtl/fecpr_pkg.sv
package fecpr_pkg;

  localparam int ADDR_W      = 32;
  localparam int DATA_W      = 32;
  localparam int LIMIT_W     = 19;
  localparam int TOTAL_WORDS = 65536;
  localparam int PAGE_WORDS  = 256;
  localparam int WIDX_W      = $clog2(TOTAL_WORDS);
  localparam int POFF_W      = $clog2(PAGE_WORDS);
  localparam int PAGE_W      = WIDX_W - POFF_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(262144);
  localparam logic [DATA_W-1:0]  ERASED_WORD = '1;

  typedef enum logic [1:0] {
    ACT_WORD = 2'd0,
    ACT_HALF = 2'd1,
    ACT_BYTE = 2'd2,
    ACT_READ = 2'd3
  } action_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic lookup;
    logic cap_read;
    logic direct_wr;
    logic mark_rewrite;
    logic copy_step;
    logic erase_step;
    logic prog_step;
    logic res_push;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic oor;
    logic is_read;
    logic lane_erased;
    logic idx_last;
    logic res_free;
  } dp_sts_t;

endpackage

### rtl/fecpr_item_if.sv
interface fecpr_item_if import fecpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] data;

  modport source (output valid, output action, output address, output data, input ready);
  modport sink (input valid, input action, input address, input data, output ready);
endinterface

### rtl/fecpr_result_if.sv
interface fecpr_result_if import fecpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic              page_rewritten;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, output status, output page_rewritten, output read_data,
                  input ready);
  modport sink (input valid, input status, input page_rewritten, input read_data,
                output ready);
endinterface

### rtl/fecpr_ctrl.sv
module fecpr_ctrl import fecpr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_DECIDE,
    S_COPY,
    S_ERASE,
    S_PROG,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.oor) begin
          state_next = S_RESULT;
        end else begin
          cmd.lookup = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (sts.is_read) begin
          cmd.cap_read = 1'b1;
          state_next   = S_RESULT;
        end else if (sts.lane_erased) begin
          cmd.direct_wr = 1'b1;
          state_next    = S_RESULT;
        end else begin
          cmd.mark_rewrite = 1'b1;
          state_next       = S_COPY;
        end
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.idx_last) state_next = S_ERASE;
      end
      S_ERASE: begin
        cmd.erase_step = 1'b1;
        if (sts.idx_last) state_next = S_PROG;
      end
      S_PROG: begin
        cmd.prog_step = 1'b1;
        if (sts.idx_last) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (sts.res_free) begin
          cmd.res_push = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/fecpr_dpath.sv
module fecpr_dpath import fecpr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data,
  input  logic [1:0]         in_action,
  input  logic [ADDR_W-1:0]  in_address,
  input  logic [DATA_W-1:0]  in_data,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_status,
  output logic               out_rewritten,
  output logic [DATA_W-1:0]  out_data
);

  logic [DATA_W-1:0] flash [TOTAL_WORDS];
  logic [DATA_W-1:0] pbuf  [PAGE_WORDS];

  logic [LIMIT_W-1:0] limit;
  action_t            action;
  logic [ADDR_W-1:0]  address;
  logic [DATA_W-1:0]  data;

  logic [WIDX_W-1:0] clr;
  logic [POFF_W-1:0] idx;
  logic              cp_pend;
  logic [POFF_W-1:0] cp_idx;
  logic              pg_pend;
  logic [POFF_W-1:0] pg_idx;
  logic [DATA_W-1:0] rd_word;
  logic [DATA_W-1:0] buf_word;
  logic [DATA_W-1:0] res_word;
  logic              rewritten;

  logic [WIDX_W-1:0] widx;
  logic [PAGE_W-1:0] page;
  logic [POFF_W-1:0] offset;
  logic [ADDR_W-1:0] aligned;
  logic              oor;
  logic [DATA_W-1:0] mask;
  logic [4:0]        sh;
  logic [DATA_W-1:0] val;
  logic [DATA_W-1:0] merged;

  logic              rd_en;
  logic [WIDX_W-1:0] rd_addr;
  logic              wr_en;
  logic [WIDX_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;

  assign widx    = address[WIDX_W+1:2];
  assign page    = widx[WIDX_W-1:POFF_W];
  assign offset  = widx[POFF_W-1:0];
  assign aligned = {address[ADDR_W-1:2], 2'b00};
  assign oor     = (aligned >= {{(ADDR_W-LIMIT_W){1'b0}}, limit})
                   || (address[ADDR_W-1:WIDX_W+2] != '0);

  always_comb begin
    unique case (action)
      ACT_WORD: begin
        sh   = 5'd0;
        mask = '1;
      end
      ACT_HALF: begin
        sh   = {address[1], 4'b0000};
        mask = DATA_W'(32'h0000_FFFF) << sh;
      end
      ACT_BYTE, ACT_READ: begin
        sh   = {address[1:0], 3'b000};
        mask = DATA_W'(32'h0000_00FF) << sh;
      end
      default: begin
        sh   = 5'd0;
        mask = '1;
      end
    endcase
  end

  assign val    = (data << sh) & mask;
  assign merged = (rd_word & ~mask) | val;

  assign sts.clr_last    = (clr == WIDX_W'(TOTAL_WORDS - 1));
  assign sts.oor         = oor;
  assign sts.is_read     = (action == ACT_READ);
  assign sts.lane_erased = ((rd_word & mask) == mask);
  assign sts.idx_last    = (idx == POFF_W'(PAGE_WORDS - 1));
  assign sts.res_free    = !out_valid || out_ready;

  assign rd_en   = cmd.lookup || cmd.copy_step;
  assign rd_addr = cmd.copy_step ? {page, idx} : widx;

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = widx;
    wr_data = ERASED_WORD;
    priority if (cmd.clr_step) begin
      wr_addr = clr;
    end else if (cmd.direct_wr) begin
      wr_data = merged;
    end else if (cmd.erase_step) begin
      wr_addr = {page, idx};
    end else if (pg_pend) begin
      wr_addr = {page, pg_idx};
      wr_data = buf_word;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) flash[wr_addr] <= wr_data;
    if (rd_en) rd_word <= flash[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cp_pend) pbuf[cp_idx] <= (cp_idx == offset) ? merged : rd_word;
    if (cmd.prog_step) buf_word <= pbuf[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit     <= LIMIT_RESET;
      clr       <= '0;
      idx       <= '0;
      cp_pend   <= 1'b0;
      pg_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) limit <= cfg_data;
      if (cmd.clr_step) clr <= clr + 1'b1;
      if (cmd.copy_step || cmd.erase_step || cmd.prog_step) idx <= idx + 1'b1;
      cp_pend <= cmd.copy_step;
      pg_pend <= cmd.prog_step;
      if (cmd.res_push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_idx <= idx;
    pg_idx <= idx;
    if (cmd.load) begin
      action    <= action_t'(in_action);
      address   <= in_address;
      data      <= in_data;
      rewritten <= 1'b0;
    end
    if (cmd.mark_rewrite) rewritten <= 1'b1;
    if (cmd.cap_read) res_word <= rd_word;
    if (cmd.direct_wr) res_word <= merged;
    if (cp_pend && (cp_idx == offset)) res_word <= merged;
    if (cmd.res_push) begin
      out_status    <= oor;
      out_rewritten <= rewritten;
      out_data      <= oor ? '0 : res_word;
    end
  end

endmodule

### rtl/flash_erase_check_page_rewrite.sv
// Out of range a beat goes from check to result; a read or a write into an erased lane
// goes through check and decide to result; a page rewrite adds copy, erase and program.
// One item at a time; the next beat can be taken once the result is registered.
// The page rewrite is bound by the flash array: copy, erase and program pass over
// the page one word per cycle. Reset is synchronous; after it a sweep over all TOTAL_WORDS
// words writes every word erased while ready stays low.
module flash_erase_check_page_rewrite import fecpr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [LIMIT_W-1:0]    cfg_data,
  fecpr_item_if.sink            req,
  fecpr_result_if.source        rsp
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  fecpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fecpr_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_action     (req.action),
    .in_address    (req.address),
    .in_data       (req.data),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (rsp.ready),
    .out_valid     (rsp.valid),
    .out_status    (rsp.status),
    .out_rewritten (rsp.page_rewritten),
    .out_data      (rsp.read_data)
  );

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_push |-> sts.res_free)
    else $error("result pushed into a full output register");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second beat accepted while an item is in work");

  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_step, cmd.direct_wr, cmd.erase_step, cmd.copy_step, cmd.prog_step,
              cmd.lookup}))
    else $error("conflicting flash port commands");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status) |-> (!rsp.page_rewritten && (rsp.read_data == '0)))
    else $error("rejected beat carries data");

endmodule

### tb/flash_store_checker.sv
module flash_store_checker import fecpr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data,
  fecpr_item_if              req,
  fecpr_result_if            rsp,
  output int                 mismatches,
  output int                 in_flight
);

  typedef struct packed {
    logic              status;
    logic              page_rewritten;
    logic [DATA_W-1:0] read_data;
  } outcome_t;

  logic [DATA_W-1:0] flash_image [int];
  logic [LIMIT_W-1:0] byte_limit;
  outcome_t pending_outcomes [$];

  function automatic outcome_t apply_to_flash_image(action_t act, logic [ADDR_W-1:0] addr,
                                                    logic [DATA_W-1:0] data);
    outcome_t res;
    logic [ADDR_W-1:0] aligned;
    logic [DATA_W-1:0] stored, lane_mask, lane_val;
    logic [4:0] shift;
    int widx;
    aligned = {addr[ADDR_W-1:2], 2'b00};
    widx = int'(addr[WIDX_W+1:2]);
    res = '0;
    if (aligned >= ADDR_W'(byte_limit) || addr[ADDR_W-1:WIDX_W+2] != '0) begin
      res.status = 1'b1;
      return res;
    end
    stored = flash_image.exists(widx) ? flash_image[widx] : ERASED_WORD;
    if (act != ACT_READ) begin
      case (act)
        ACT_WORD: begin
          lane_mask = '1;
          lane_val = data;
        end
        ACT_HALF: begin
          shift = {addr[1], 4'b0000};
          lane_mask = 32'h0000_FFFF << shift;
          lane_val = {16'h0000, data[15:0]} << shift;
        end
        default: begin
          shift = {addr[1:0], 3'b000};
          lane_mask = 32'h0000_00FF << shift;
          lane_val = {24'h000000, data[7:0]} << shift;
        end
      endcase
      res.page_rewritten = (stored & lane_mask) != lane_mask;
      stored = (stored & ~lane_mask) | lane_val;
      flash_image[widx] = stored;
    end
    res.read_data = stored;
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t got, want;
    if (rst) begin
      byte_limit = LIMIT_RESET;
      flash_image.delete();
      pending_outcomes.delete();
      in_flight = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.status = rsp.status;
        got.page_rewritten = rsp.page_rewritten;
        got.read_data = rsp.read_data;
        if (pending_outcomes.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, expected none, got status %0d rewritten %0d data %h",
                   $time, got.status, got.page_rewritten, got.read_data);
        end else begin
          want = pending_outcomes.pop_front();
          in_flight--;
          if (got.status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
          end
          if (got.page_rewritten !== want.page_rewritten) begin
            mismatches++;
            $display("%0t: page_rewritten expected %0d, got %0d",
                     $time, want.page_rewritten, got.page_rewritten);
          end
          if (got.read_data !== want.read_data) begin
            mismatches++;
            $display("%0t: read_data expected %h, got %h", $time, want.read_data, got.read_data);
          end
        end
      end
      if (req.valid && req.ready) begin
        pending_outcomes.push_back(apply_to_flash_image(action_t'(req.action), req.address,
                                                        req.data));
        in_flight++;
      end
      if (cfg_we) begin
        byte_limit = cfg_data;
      end
    end
  end

endmodule

### tb/flash_erase_check_page_rewrite_test.sv
module flash_erase_check_page_rewrite_test;
  import fecpr_pkg::*;

  localparam int QUIET_LIMIT = 200000;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_data;
  logic [LIMIT_W-1:0] limit_now;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  int                 mismatches;
  int                 in_flight;
  int                 quiet_cycles;

  fecpr_item_if   req_ch ();
  fecpr_result_if rsp_ch ();

  flash_erase_check_page_rewrite i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  flash_store_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_beat(action_t act, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.action  <= act;
    req_ch.address <= addr;
    req_ch.data    <= data;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
  endtask

  task automatic program_limit(logic [LIMIT_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_data  <= value;
    limit_now = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_op();
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    int pick;
    pick = $urandom_range(0, 99);
    data = $urandom();
    if (pick < 10) begin
      addr = $urandom();
    end else if (pick < 40) begin
      addr = $urandom_range(0, 31);
    end else if (pick < 60) begin
      addr = 32'h400 + $urandom_range(0, 1023);
    end else if (pick < 75) begin
      addr = 32'h3FC00 + $urandom_range(0, 1023);
    end else if (pick < 88) begin
      addr = $urandom_range(0, 32'h3FFFF);
    end else begin
      addr = ADDR_W'(limit_now) + $urandom_range(0, 15) - 8;
    end
    if ($urandom_range(0, 9) == 0) begin
      data = '1;
    end
    send_beat(action_t'($urandom_range(0, 3)), addr, data);
  endtask

  task automatic run_phase(logic [LIMIT_W-1:0] value, int idle_pct, int stall_pct, int count);
    program_limit(value);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_random_op();
  endtask

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    limit_now      = LIMIT_RESET;
    req_ch.valid   = 1'b0;
    req_ch.action  = ACT_READ;
    req_ch.address = '0;
    req_ch.data    = '0;
    send_idle_pct  = 12;
    recv_stall_pct = 61;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    send_beat(ACT_READ, 32'h0000_0000, 32'h0);
    send_beat(ACT_WORD, 32'h0000_0000, 32'h1234_5678);
    send_beat(ACT_BYTE, 32'h0000_0003, 32'h0000_00AB);
    send_beat(ACT_HALF, 32'h0000_0006, 32'hFFFF_5A5A);
    send_beat(ACT_HALF, 32'h0000_0004, 32'h0000_0000);
    send_beat(ACT_HALF, 32'h0000_0004, 32'h0000_1234);
    send_beat(ACT_BYTE, 32'h0000_0008, 32'h0000_0000);
    send_beat(ACT_BYTE, 32'h0000_0009, 32'hFFFF_FFFF);
    send_beat(ACT_BYTE, 32'h0000_000A, 32'h0000_0080);
    send_beat(ACT_BYTE, 32'h0000_000B, 32'h0000_007F);
    send_beat(ACT_BYTE, 32'h0000_0009, 32'h0000_0055);
    send_beat(ACT_WORD, 32'h0000_000C, 32'hFFFF_FFFF);
    send_beat(ACT_WORD, 32'h0000_000C, 32'h0000_0000);
    send_beat(ACT_WORD, 32'h0000_0013, 32'h0000_0000);
    send_beat(ACT_WORD, 32'h0003_FFFC, 32'h0000_0000);
    send_beat(ACT_READ, 32'h0003_FFFF, 32'hFFFF_FFFF);
    send_beat(ACT_WORD, 32'h0004_0000, 32'h0000_0000);
    send_beat(ACT_READ, 32'hFFFF_FFFF, 32'h0);
    send_beat(ACT_BYTE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_beat(ACT_WORD, 32'h0000_0400, 32'hA5A5_A5A5);
    send_beat(ACT_WORD, 32'h0000_03FC, 32'h0F0F_0F0F);
    send_beat(ACT_HALF, 32'h0000_03FE, 32'h0000_0000);
    send_beat(ACT_READ, 32'h0000_0000, 32'h0);

    run_phase(LIMIT_RESET, 12, 61, 230);
    run_phase('1, 12, 61, 100);
    run_phase('0, 61, 12, 60);
    run_phase(LIMIT_W'($urandom_range(1, 262143)), 61, 12, 220);
    run_phase(LIMIT_W'($urandom()), 0, 0, 200);
    run_phase(LIMIT_W'(262140), 0, 0, 170);

    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/fecpr_pkg.sv
rtl/fecpr_item_if.sv
rtl/fecpr_result_if.sv
rtl/fecpr_ctrl.sv
rtl/fecpr_dpath.sv
rtl/flash_erase_check_page_rewrite.sv
tb/flash_store_checker.sv
tb/flash_erase_check_page_rewrite_test.sv
